// File: rtl/gdda_pkg.sv
// Shared types and constants of the grid DDA ray caster.
package gdda_pkg;

	localparam int REG_W     = 16;
	localparam int COL_W     = 10;
	localparam int IDX_W     = 6;
	localparam int CELL_W    = 10;            // signed walk cell, covers -1..257
	localparam int DVD_W     = 32;
	localparam int DSR_W     = 28;
	localparam int CAM_W     = 26;
	localparam int PROD_W    = 42;
	localparam int RAY_W     = 28;
	localparam int SPOS_W    = 11;
	localparam int DIST_W    = 24;
	localparam int QDEPTH    = 2;

	localparam logic [31:0]       SAT32     = 32'hFFFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFF_FFFF;
	localparam logic [9:0]        NUDGE_Q10 = 10'd10;
	localparam logic [SPOS_W-1:0] ONE_Q10   = 11'd1024;
	localparam logic [CAM_W-1:0]  CAM_BIAS  = 26'd16384;
	localparam logic [DVD_W-1:0]  RECIP_NUM = 32'h0100_0000;

	typedef enum logic [2:0] {
		REG_PLAYER_X    = 3'd0,
		REG_PLAYER_Y    = 3'd1,
		REG_VIEW_DIR_X  = 3'd2,
		REG_VIEW_DIR_Y  = 3'd3,
		REG_CAM_PLANE_X = 3'd4,
		REG_CAM_PLANE_Y = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_SKIP  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CAST  = 2'd2
	} op_t;

	typedef struct packed {
		logic             mode;
		logic [COL_W-1:0] column;
		logic [IDX_W-1:0] cell_x;
		logic [IDX_W-1:0] cell_y;
		logic             cell_is_wall;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] wall_distance;
		logic              hit_side;
		logic [IDX_W-1:0]  hit_x;
		logic [IDX_W-1:0]  hit_y;
		logic              left_map;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [COL_W-1:0] column;
		logic [IDX_W-1:0] cell_x;
		logic [IDX_W-1:0] cell_y;
		logic             wall;
	} qent_t;

	typedef struct packed {
		logic [REG_W-1:0]        player_x;
		logic [REG_W-1:0]        player_y;
		logic signed [REG_W-1:0] view_dir_x;
		logic signed [REG_W-1:0] view_dir_y;
		logic signed [REG_W-1:0] cam_plane_x;
		logic signed [REG_W-1:0] cam_plane_y;
	} cfg_t;

endpackage

// File: rtl/grid_dda_ray_caster_top.sv
// Top level of the grid DDA ray caster: register file, front end and walker.
//
//  channel   signals                          payload
//  request   cast_valid / cast_ready          cast_req   (gdda_pkg::req_t)
//  result    result_valid / result_ready      result     (gdda_pkg::rsp_t)
//  config    wr_en, wr_index                  wr_data    (16 bit, no wait)
//
//  A map write is done by the walker straight from idle; a cast runs the
//  bit-serial divider twice (two reciprocals) and the setup steps (camera
//  coordinate by constant multiply, plane product, ray, two setup steps),
//  then a step and a registered map read for each grid cell walked,
//  up to about 2 x MAP_SIDE cells, and then loads the result.
//  After reset the map is cleared one cell a cycle, all MAP_SIDE x MAP_SIDE
//  cells, during which no request is taken; config writes still land.
//  Requests queue two deep ahead of the walker; a waiting result sits in
//  its output register while the next request is already being worked.
module grid_dda_ray_caster_top #(
	parameter int SCREEN_COLS = 640,
	parameter int MAP_SIDE    = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cast_valid,
	output logic                        cast_ready,
	input  gdda_pkg::req_t              cast_req,
	output logic                        result_valid,
	input  logic                        result_ready,
	output gdda_pkg::rsp_t              result,
	input  logic                        wr_en,
	input  logic [2:0]                  wr_index,
	input  logic [gdda_pkg::REG_W-1:0]  wr_data
);
	import gdda_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid, q_pop, clearing;
	qent_t q_ent;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x    <= 16'd2560;
			cfg_q.player_y    <= 16'd2560;
			cfg_q.view_dir_x  <= 16'sd16384;
			cfg_q.view_dir_y  <= 16'sd0;
			cfg_q.cam_plane_x <= 16'sd0;
			cfg_q.cam_plane_y <= 16'sd10813;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PLAYER_X:    cfg_q.player_x    <= wr_data;
				REG_PLAYER_Y:    cfg_q.player_y    <= wr_data;
				REG_VIEW_DIR_X:  cfg_q.view_dir_x  <= wr_data;
				REG_VIEW_DIR_Y:  cfg_q.view_dir_y  <= wr_data;
				REG_CAM_PLANE_X: cfg_q.cam_plane_x <= wr_data;
				REG_CAM_PLANE_Y: cfg_q.cam_plane_y <= wr_data;
				default: ;
			endcase
		end
	end

	gdda_front #(
		.MAP_SIDE (MAP_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (cast_req),
		.req_valid (cast_valid),
		.req_ready (cast_ready),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop)
	);

	gdda_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.MAP_SIDE    (MAP_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.rsp_valid (result_valid),
		.rsp_ready (result_ready),
		.rsp       (result)
	);

endmodule

// File: rtl/gdda_front.sv
// Front end: accepts requests, classifies them and queues them for the walker.
module gdda_front #(
	parameter int MAP_SIDE = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gdda_pkg::req_t  req,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic            clearing,
	output logic            q_valid,
	output gdda_pkg::qent_t q_ent,
	input  logic            q_pop
);
	import gdda_pkg::*;

	qent_t       ent_q [QDEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	qent_t       cls;
	logic        push;

	always_comb begin
		cls.column = req.column;
		cls.cell_x = req.cell_x;
		cls.cell_y = req.cell_y;
		cls.wall   = req.cell_is_wall;
		if (req.mode) begin
			cls.op = OP_CAST;
		end else if (int'(req.cell_x) < MAP_SIDE && int'(req.cell_y) < MAP_SIDE) begin
			cls.op = OP_WRITE;
		end else begin
			cls.op = OP_SKIP;
		end
	end

	assign req_ready = !clearing && (cnt_q != 2'(QDEPTH));
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_ent     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= cls;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH))
		else $error("request queue overflow");
`endif

endmodule

// File: rtl/gdda_div.sv
// Restoring divider, one quotient bit per cycle.
module gdda_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gdda_pkg::DVD_W-1:0] dividend,
	input  logic [gdda_pkg::DSR_W-1:0] divisor,
	output logic                       done,
	output logic [gdda_pkg::DVD_W-1:0] quot
);
	import gdda_pkg::*;

	logic [DVD_W-1:0] dq_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   rem_q, trial, rem_n;
	logic [5:0]       cnt_q;
	logic             busy_q, qbit;

	always_comb begin
		trial = {rem_q[DSR_W-1:0], dq_q[DVD_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
		rem_n = qbit ? (trial - {1'b0, dsr_q}) : trial;
	end

	assign quot = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], qbit};
			rem_q <= rem_n;
		end
	end

endmodule

// File: rtl/gdda_back.sv
// Back end: wall map memory, ray setup sequencer and DDA grid walker.
module gdda_back #(
	parameter int SCREEN_COLS = 640,
	parameter int MAP_SIDE    = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gdda_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  gdda_pkg::qent_t q_ent,
	output logic            q_pop,
	output logic            clearing,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gdda_pkg::rsp_t  rsp
);
	import gdda_pkg::*;

	localparam int DEPTH    = MAP_SIDE * MAP_SIDE;
	localparam int AW       = $clog2(DEPTH);
	localparam int WALK_MAX = 4 * MAP_SIDE + 256;
	localparam int WCW      = $clog2(WALK_MAX + 1);

	// camera coordinate: column * 2^15 / SCREEN_COLS as a reciprocal multiply,
	// exact for every 25-bit dividend (column is 10 bits, shifted by 15)
	localparam int CAM_L  = $clog2(SCREEN_COLS);
	localparam int CAM_MW = 27;
	localparam longint unsigned CAM_MUL =
		((64'd1 << (25 + CAM_L)) + 64'(SCREEN_COLS - 1)) / 64'(SCREEN_COLS);

	typedef enum logic [10:0] {
		ST_CLR   = 11'b000_0000_0001,
		ST_IDLE  = 11'b000_0000_0010,
		ST_CAM   = 11'b000_0000_0100,
		ST_MUL   = 11'b000_0000_1000,
		ST_RAY   = 11'b000_0001_0000,
		ST_RECX  = 11'b000_0010_0000,
		ST_RECY  = 11'b000_0100_0000,
		ST_SETUP = 11'b000_1000_0000,
		ST_SAT   = 11'b001_0000_0000,
		ST_STEP  = 11'b010_0000_0000,
		ST_CHECK = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic   fin_q;

	// map memory
	logic          mem [DEPTH];
	logic          mem_we, mem_wd, mem_rd_q;
	logic [AW-1:0] mem_wa, mem_ra, clr_cnt_q;

	// divider
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_quot;
	logic [DSR_W-1:0] div_dsr;

	// cast payload
	logic [COL_W+CAM_MW-1:0]  cam_prod;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [PROD_W-1:0] prodx_q, prody_q;
	logic signed [RAY_W-1:0]  rx_q, ry_q, rx_c, ry_c;
	logic [DSR_W-1:0]         absx, absy;
	logic [31:0]              stepx_q, stepy_q, ncx_q, ncy_q;
	logic [SPOS_W+31:0]       spx_q, spy_q;
	logic [CELL_W-1:0]        x_q, y_q;
	logic                     negx_q, negy_q, side_q, left_q;
	logic [WCW-1:0]           wcnt_q;
	logic [COL_W-1:0]         col_q;

	// walk step
	logic              take_x, x_out, y_out;
	logic [32:0]       sum;
	logic [31:0]       sum_sat;
	logic [CELL_W-1:0] x_n, y_n;

	// setup
	logic [9:0]        fx, fy;
	logic [SPOS_W-1:0] sposx, sposy;

	// finish
	logic [31:0]       last, lstep, diff;
	logic [DIST_W-1:0] wall_dist;
	logic              rsp_load;

	gdda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign clearing = (state_q == ST_CLR);
	assign q_pop    = (state_q == ST_IDLE) && !fin_q && q_valid;

	assign cam_prod = (COL_W+CAM_MW)'(col_q) * (COL_W+CAM_MW)'(CAM_MUL);

	// ray direction, floor of the Q.14 product is an arithmetic shift
	assign rx_c = {{(RAY_W-REG_W){cfg.view_dir_x[REG_W-1]}}, cfg.view_dir_x}
		+ RAY_W'(prodx_q >>> 14);
	assign ry_c = {{(RAY_W-REG_W){cfg.view_dir_y[REG_W-1]}}, cfg.view_dir_y}
		+ RAY_W'(prody_q >>> 14);
	assign absx = rx_q[RAY_W-1] ? DSR_W'(-rx_q) : DSR_W'(rx_q);
	assign absy = ry_q[RAY_W-1] ? DSR_W'(-ry_q) : DSR_W'(ry_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = RECIP_NUM;
		div_dsr   = absx;
		if (state_q == ST_RAY) begin
			div_start = 1'b1;
			div_dsr   = DSR_W'(rx_c[RAY_W-1] ? -rx_c : rx_c);
		end else if (state_q == ST_RECX && div_done) begin
			div_start = 1'b1;
			div_dsr   = absy;
		end
	end

	// position fraction with the small-fraction nudge
	always_comb begin
		fx = cfg.player_x[9:0];
		fy = cfg.player_y[9:0];
		if (fx < NUDGE_Q10) fx = fx + NUDGE_Q10;
		if (fy < NUDGE_Q10) fy = fy + NUDGE_Q10;
		sposx = rx_q[RAY_W-1] ? SPOS_W'(fx) : ONE_Q10 - SPOS_W'(fx);
		sposy = ry_q[RAY_W-1] ? SPOS_W'(fy) : ONE_Q10 - SPOS_W'(fy);
	end

	// one DDA step
	always_comb begin
		take_x  = (ncx_q < ncy_q);
		sum     = take_x ? ({1'b0, ncx_q} + {1'b0, stepx_q})
			: ({1'b0, ncy_q} + {1'b0, stepy_q});
		sum_sat = sum[32] ? SAT32 : sum[31:0];
		x_n     = x_q;
		y_n     = y_q;
		if (take_x) begin
			x_n = negx_q ? x_q - CELL_W'(1) : x_q + CELL_W'(1);
		end else begin
			y_n = negy_q ? y_q - CELL_W'(1) : y_q + CELL_W'(1);
		end
		x_out  = x_n[CELL_W-1] || (int'(x_n) >= MAP_SIDE);
		y_out  = y_n[CELL_W-1] || (int'(y_n) >= MAP_SIDE);
		mem_ra = AW'(AW'(x_n[7:0]) * AW'(MAP_SIDE) + AW'(y_n[7:0]));
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = 1'b0;
		mem_wa = clr_cnt_q;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
		end else if (q_pop && q_ent.op == OP_WRITE) begin
			mem_we = 1'b1;
			mem_wd = q_ent.wall;
			mem_wa = AW'(AW'(q_ent.cell_x) * AW'(MAP_SIDE) + AW'(q_ent.cell_y));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// distance of the last crossed side
	always_comb begin
		last  = side_q ? ncy_q : ncx_q;
		lstep = side_q ? stepy_q : stepx_q;
		diff  = last - lstep;
		if (last == SAT32 || diff > 32'(DIST_MAX)) begin
			wall_dist = DIST_MAX;
		end else begin
			wall_dist = diff[DIST_W-1:0];
		end
		rsp_load = fin_q && (!rsp_valid || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			fin_q     <= 1'b0;
			rsp_valid <= 1'b0;
			wcnt_q    <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid <= 1'b1;
				fin_q     <= 1'b0;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop && q_ent.op == OP_CAST) state_q <= ST_CAM;
				end
				ST_CAM:   state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_RAY;
				ST_RAY:   state_q <= ST_RECX;
				ST_RECX:  if (div_done) state_q <= ST_RECY;
				ST_RECY:  if (div_done) state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_SAT;
				ST_SAT: begin
					wcnt_q  <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					wcnt_q <= wcnt_q + WCW'(1);
					if (x_out || y_out) begin
						fin_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (mem_rd_q || wcnt_q == WCW'(WALK_MAX)) begin
						fin_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) col_q <= q_ent.column;
		if (state_q == ST_CAM) begin
			cam_q <= CAM_W'(cam_prod >> (10 + CAM_L)) - CAM_BIAS;
		end
		if (state_q == ST_MUL) begin
			prodx_q <= cfg.cam_plane_x * cam_q;
			prody_q <= cfg.cam_plane_y * cam_q;
		end
		if (state_q == ST_RAY) begin
			rx_q <= rx_c;
			ry_q <= ry_c;
		end
		if (state_q == ST_RECX && div_done) begin
			stepx_q <= (absx == '0) ? SAT32 : div_quot;
		end
		if (state_q == ST_RECY && div_done) begin
			stepy_q <= (absy == '0) ? SAT32 : div_quot;
		end
		if (state_q == ST_SETUP) begin
			spx_q <= (SPOS_W+32)'(sposx) * (SPOS_W+32)'(stepx_q);
			spy_q <= (SPOS_W+32)'(sposy) * (SPOS_W+32)'(stepy_q);
		end
		if (state_q == ST_SAT) begin
			ncx_q  <= spx_q[SPOS_W+31] ? SAT32 : spx_q[41:10];
			ncy_q  <= spy_q[SPOS_W+31] ? SAT32 : spy_q[41:10];
			x_q    <= CELL_W'(cfg.player_x[15:10]);
			y_q    <= CELL_W'(cfg.player_y[15:10]);
			negx_q <= rx_q[RAY_W-1];
			negy_q <= ry_q[RAY_W-1];
			side_q <= 1'b0;
			left_q <= 1'b1;
		end
		if (state_q == ST_STEP) begin
			x_q    <= x_n;
			y_q    <= y_n;
			side_q <= !take_x;
			if (take_x) ncx_q <= sum_sat;
			else        ncy_q <= sum_sat;
			left_q <= x_out || y_out;
		end
		if (state_q == ST_CHECK) begin
			left_q <= !mem_rd_q;
		end
		if (rsp_load) begin
			rsp.wall_distance <= wall_dist;
			rsp.hit_side      <= side_q;
			rsp.hit_x         <= x_q[IDX_W-1:0];
			rsp.hit_y         <= y_q[IDX_W-1:0];
			rsp.left_map      <= left_q;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !q_pop)
		else $error("queue popped during map clear");
	a_sat_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && ncx_q == SAT32) |=> (ncx_q == SAT32))
		else $error("saturated crossing distance dropped");
	a_check_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (wcnt_q != '0))
		else $error("cell check without a step");
`endif

endmodule
